[src/bgr_to_hsv_pixel_defines.svh]
// Assertion macros shared by the converter's RTL files.
`ifndef BGR_TO_HSV_PIXEL_DEFINES_SVH
`define BGR_TO_HSV_PIXEL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BTH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bth_pkg.sv]
// Types and constants for the BGR to HSV pixel converter.
package bth_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_W   = 2 * CHAN_W;
  localparam int unsigned DIV_STEPS = CHAN_W;

  localparam logic [NUM_W-1:0] HUE_STEP     = NUM_W'(30);
  localparam logic [NUM_W-1:0] HUE_GREEN    = NUM_W'(60);
  localparam logic [NUM_W-1:0] HUE_BLUE     = NUM_W'(120);
  localparam logic [NUM_W-1:0] HUE_RED_WRAP = NUM_W'(180);
  localparam logic [NUM_W-1:0] SAT_SCALE    = NUM_W'(255);
  localparam logic [CHAN_W-1:0] HUE_LIMIT   = CHAN_W'(180);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Front stage A contents.
  typedef struct packed {
    sector_t            sector;
    logic               neg;
    logic [CHAN_W-1:0]  ad;
    logic [CHAN_W-1:0]  d;
    logic [CHAN_W-1:0]  mx;
  } front_t;

  // One division in flight: partial remainder, numerator bits shifting out
  // while quotient bits shift in, and the divisor.
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] shq;
    logic [CHAN_W-1:0] den;
  } quo_t;

  typedef struct packed {
    quo_t              hue;
    quo_t              sat;
    logic [CHAN_W-1:0] bright;
  } pix_t;

endpackage

[src/bth_front.sv]
// Front end: max/min and sector decode, then hue and saturation numerators.
module bth_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [bth_pkg::CHAN_W-1:0] blue_i,
  input  logic [bth_pkg::CHAN_W-1:0] green_i,
  input  logic [bth_pkg::CHAN_W-1:0] red_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output bth_pkg::pix_t              pix_o
);

  bth_pkg::front_t a_nxt, a_r;
  logic            a_v_r, a_ready;
  bth_pkg::pix_t   b_nxt, b_r;
  logic            b_v_r, b_ready;

  logic [bth_pkg::CHAN_W-1:0] mx, mn;
  logic [bth_pkg::NUM_W-1:0]  d16, ad30, base, hue_num, sat_num;

  // Stage A: largest channel, spread, sector and signed channel difference
  always_comb begin
    mx = blue_i;
    mn = blue_i;
    if (green_i > mx) mx = green_i;
    if (red_i > mx) mx = red_i;
    if (green_i < mn) mn = green_i;
    if (red_i < mn) mn = red_i;
    a_nxt.mx = mx;
    a_nxt.d  = mx - mn;
    if (red_i >= mx) begin
      a_nxt.sector = bth_pkg::SEC_RED;
      a_nxt.neg    = green_i < blue_i;
      a_nxt.ad     = a_nxt.neg ? blue_i - green_i : green_i - blue_i;
    end else if (green_i >= mx) begin
      a_nxt.sector = bth_pkg::SEC_GREEN;
      a_nxt.neg    = blue_i < red_i;
      a_nxt.ad     = a_nxt.neg ? red_i - blue_i : blue_i - red_i;
    end else begin
      a_nxt.sector = bth_pkg::SEC_BLUE;
      a_nxt.neg    = red_i < green_i;
      a_nxt.ad     = a_nxt.neg ? green_i - red_i : red_i - green_i;
    end
  end

  assign a_ready = !a_v_r || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= valid_i;
    end
    if (a_ready && valid_i) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: numerators; the divider starts with the high byte as remainder
  always_comb begin
    d16  = bth_pkg::NUM_W'(a_r.d);
    ad30 = bth_pkg::NUM_W'(a_r.ad) * bth_pkg::HUE_STEP;
    unique case (a_r.sector)
      bth_pkg::SEC_RED:   base = a_r.neg ? d16 * bth_pkg::HUE_RED_WRAP : '0;
      bth_pkg::SEC_GREEN: base = d16 * bth_pkg::HUE_GREEN;
      bth_pkg::SEC_BLUE:  base = d16 * bth_pkg::HUE_BLUE;
      default:            base = '0;
    endcase
    hue_num = a_r.neg ? base - ad30 : base + ad30;
    sat_num = d16 * bth_pkg::SAT_SCALE;
    b_nxt.bright = a_r.mx;
    if (a_r.d == '0) begin
      // grey: zero over one gives zero hue and saturation
      b_nxt.hue.rem = '0;
      b_nxt.hue.shq = '0;
      b_nxt.hue.den = bth_pkg::CHAN_W'(1);
      b_nxt.sat.rem = '0;
      b_nxt.sat.shq = '0;
      b_nxt.sat.den = bth_pkg::CHAN_W'(1);
    end else begin
      b_nxt.hue.rem = hue_num[bth_pkg::NUM_W-1:bth_pkg::CHAN_W];
      b_nxt.hue.shq = hue_num[bth_pkg::CHAN_W-1:0];
      b_nxt.hue.den = a_r.d;
      b_nxt.sat.rem = sat_num[bth_pkg::NUM_W-1:bth_pkg::CHAN_W];
      b_nxt.sat.shq = sat_num[bth_pkg::CHAN_W-1:0];
      b_nxt.sat.den = a_r.mx;
    end
  end

  assign b_ready = !b_v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
    if (b_ready && a_v_r) begin
      b_r <= b_nxt;
    end
  end

  assign valid_o = b_v_r;
  assign pix_o   = b_r;

endmodule

[src/bth_div_stage.sv]
// One restoring-division step for both hue and saturation, registered.
`include "bgr_to_hsv_pixel_defines.svh"

module bth_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  bth_pkg::pix_t pix_i,
  output logic          valid_o,
  input  logic          ready_i,
  output bth_pkg::pix_t pix_o
);

  bth_pkg::pix_t pix_nxt, pix_r;
  logic          v_r;

  function automatic bth_pkg::quo_t step(input bth_pkg::quo_t q);
    logic [bth_pkg::CHAN_W:0] t;
    logic [bth_pkg::CHAN_W:0] diff;
    logic                     ge;
    bth_pkg::quo_t            res;
    t        = {q.rem, q.shq[bth_pkg::CHAN_W-1]};
    diff     = t - {1'b0, q.den};
    ge       = t >= {1'b0, q.den};
    // remainder stays below the divisor, so it fits the channel width
    res.rem  = ge ? diff[bth_pkg::CHAN_W-1:0] : t[bth_pkg::CHAN_W-1:0];
    res.shq  = {q.shq[bth_pkg::CHAN_W-2:0], ge};
    res.den  = q.den;
    return res;
  endfunction

  always_comb begin
    pix_nxt.hue    = step(pix_i.hue);
    pix_nxt.sat    = step(pix_i.sat);
    pix_nxt.bright = pix_i.bright;
  end

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_o = v_r;
  assign pix_o   = pix_r;

  `BTH_ASSERT_NOW(a_hue_rem_lt_den, v_r, pix_r.hue.rem < pix_r.hue.den, "hue remainder too big")
  `BTH_ASSERT_NOW(a_sat_rem_lt_den, v_r, pix_r.sat.rem < pix_r.sat.den, "sat remainder too big")
  `BTH_ASSERT_NEXT(a_stall_hold, v_r && !ready_i, v_r && $stable(pix_r), "stalled item lost")

endmodule

[src/bgr_to_hsv_pixel.sv]
// Pipeline: 2 front stages, then 8 divide steps, between input accept and output valid.
// Throughput: one item per cycle while out_ready is high; each stage holds one item and fills bubbles on stall.
// Hue and saturation quotients come from an 8-stage restoring divider, one bit per stage.
// Reset: synchronous active-low rst_n clears every stage valid bit; data regs not reset.
// No clearing pass; in_ready is high in the first cycle after reset.
`include "bgr_to_hsv_pixel_defines.svh"

module bgr_to_hsv_pixel (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bth_pkg::CHAN_W-1:0] in_blue,
  input  logic [bth_pkg::CHAN_W-1:0] in_green,
  input  logic [bth_pkg::CHAN_W-1:0] in_red,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bth_pkg::CHAN_W-1:0] out_hue,
  output logic [bth_pkg::CHAN_W-1:0] out_saturation,
  output logic [bth_pkg::CHAN_W-1:0] out_brightness
);

  logic          st_valid [0:bth_pkg::DIV_STEPS];
  logic          st_ready [0:bth_pkg::DIV_STEPS];
  bth_pkg::pix_t st_pix   [0:bth_pkg::DIV_STEPS];

  bth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .blue_i  (in_blue),
    .green_i (in_green),
    .red_i   (in_red),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .pix_o   (st_pix[0])
  );

  for (genvar i = 0; i < bth_pkg::DIV_STEPS; i++) begin : g_div
    bth_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .pix_i   (st_pix[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .pix_o   (st_pix[i+1])
    );
  end

  assign st_ready[bth_pkg::DIV_STEPS] = out_ready;

  // after all steps the shift field holds the quotient
  assign out_valid      = st_valid[bth_pkg::DIV_STEPS];
  assign out_hue        = st_pix[bth_pkg::DIV_STEPS].hue.shq;
  assign out_saturation = st_pix[bth_pkg::DIV_STEPS].sat.shq;
  assign out_brightness = st_pix[bth_pkg::DIV_STEPS].bright;

  `BTH_ASSERT_NOW(a_hue_range, out_valid, out_hue < bth_pkg::HUE_LIMIT, "hue out of range")
  `BTH_ASSERT_NOW(a_black, out_valid && out_brightness == '0, out_saturation == '0 && out_hue == '0, "black pixel not grey")
  `BTH_ASSERT_NOW(a_grey_hue, out_valid && out_saturation == '0, out_hue == '0, "grey pixel has hue")

endmodule

[test/tb.sv]
// Self-checking testbench for the BGR to HSV pixel converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bth_pkg::CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t hue;
    chan_t sat;
    chan_t bright;
  } hsv_t;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS   = 1800;
  localparam int unsigned MAX_REPORTS    = 10;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  chan_t in_blue = '0;
  chan_t in_green = '0;
  chan_t in_red = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  chan_t out_hue;
  chan_t out_saturation;
  chan_t out_brightness;

  hsv_t        pending_hsv[$];
  int unsigned error_count = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  bgr_to_hsv_pixel u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic hsv_t predict_hsv(input chan_t b, input chan_t g, input chan_t r);
    hsv_t             res;
    int unsigned      ib, ig, ir, mx, mn, d, num;
    bth_pkg::sector_t sec;
    ib = b;
    ig = g;
    ir = r;
    mx = ib;
    mn = ib;
    if (ig > mx) mx = ig;
    if (ir > mx) mx = ir;
    if (ig < mn) mn = ig;
    if (ir < mn) mn = ir;
    d = mx - mn;
    res.bright = chan_t'(mx);
    if (d == 0) begin
      res.hue = '0;
      res.sat = '0;
    end else begin
      res.sat = chan_t'((255 * d) / mx);
      // ties on the largest channel go red first, then green
      if (ir == mx) sec = bth_pkg::SEC_RED;
      else if (ig == mx) sec = bth_pkg::SEC_GREEN;
      else sec = bth_pkg::SEC_BLUE;
      case (sec)
        bth_pkg::SEC_RED: begin
          // negative hue wraps by adding 180 degrees-halved
          num = (ig >= ib) ? 30 * (ig - ib) : 180 * d - 30 * (ib - ig);
        end
        bth_pkg::SEC_GREEN: begin
          num = (ib >= ir) ? 60 * d + 30 * (ib - ir) : 60 * d - 30 * (ir - ib);
        end
        default: begin
          num = (ir >= ig) ? 120 * d + 30 * (ir - ig) : 120 * d - 30 * (ig - ir);
        end
      endcase
      res.hue = chan_t'(num / d);
    end
    return res;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (!in_ready);
    pending_hsv.push_back(predict_hsv(b, g, r));
  endtask

  task automatic test_extremes();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd0);
  endtask

  task automatic test_grey();
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd254, 8'd254, 8'd254);
  endtask

  task automatic test_ties();
    send_pixel(8'd10,  8'd200, 8'd200);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd200, 8'd10,  8'd200);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
  endtask

  task automatic test_sectors();
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd254, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd254);
  endtask

  task automatic test_random();
    chan_t       b, g, r, top, other;
    int unsigned kind;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        b = chan_t'($urandom);
        g = chan_t'($urandom);
        r = chan_t'($urandom);
      end else if (kind < 15) begin
        top   = chan_t'($urandom_range(1, 255));
        other = chan_t'($urandom_range(0, top));
        case ($urandom_range(0, 2))
          0: begin b = other; g = top; r = top; end
          1: begin b = top; g = top; r = other; end
          default: begin b = top; g = other; r = top; end
        endcase
      end else if (kind < 17) begin
        b = chan_t'($urandom);
        g = b;
        r = b;
      end else begin
        b = chan_t'($urandom_range(0, 3));
        g = chan_t'($urandom_range(0, 3));
        r = chan_t'($urandom_range(0, 3));
      end
      send_pixel(b, g, r);
    end
  endtask

  // Result side backpressure, one draw per item.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1));
    end
  end

  always @(posedge clk) begin
    hsv_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got = '{hue: out_hue, sat: out_saturation, bright: out_brightness};
      if (pending_hsv.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected item: hue %0d sat %0d val %0d", got.hue, got.sat, got.bright);
        error_count++;
      end else begin
        want = pending_hsv.pop_front();
        if (got !== want) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (expected/actual)",
                     want.hue, got.hue, want.sat, got.sat, want.bright, got.bright);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_grey();
    test_ties();
    test_sectors();
    test_random();
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_hsv.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bth_pkg.sv
src/bth_front.sv
src/bth_div_stage.sv
src/bgr_to_hsv_pixel.sv
test/tb.sv
